// ===== rtl/cartridge_bank_controller_rtc_assert.svh =====
// ----------------------------------------------------------------------------
// Cartridge bank controller assertion macros
// Implication checks on the rising edge of clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_RTC_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_RTC_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBC_ASSERT_NOW(lbl, ante, cons, msg)
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared constants, command codes and the clock request bundle.
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int RAM_BANKS_DEF  = 4;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
    localparam int ROM_OFF_W      = $clog2(ROM_BANK_BYTES);
    localparam int BANK_W         = 7;
    localparam int ROM_ADDR_W     = BANK_W + ROM_OFF_W;
    localparam int PERIOD_W       = 23;
    localparam int ACC_W          = 24;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 23'd4194304;
    localparam logic [ACC_W-1:0]    PERIOD_MIN   = 24'd256;
    localparam logic [3:0]          ENABLE_KEY   = 4'hA;
    localparam logic [3:0]          SEL_CLK_LO   = 4'd8;
    localparam logic [3:0]          SEL_CLK_HI   = 4'd12;
    localparam logic [3:0]          SEL_RAM_HI   = 4'd3;

    typedef enum logic [2:0] {
        CMD_ROM_RD  = 3'd0,
        CMD_RAM_RD  = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_BANK    = 3'd3,
        CMD_SELECT  = 3'd4,
        CMD_LATCH   = 3'd5,
        CMD_RAM_WR  = 3'd6,
        CMD_TICK    = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        RTC_SEC  = 3'd0,
        RTC_MIN  = 3'd1,
        RTC_HOUR = 3'd2,
        RTC_DLO  = 3'd3,
        RTC_DHI  = 3'd4
    } rtc_reg_t;

    typedef struct packed {
        logic       tick;
        logic       clk_wr;
        logic       latch_wr;
        rtc_reg_t   reg_sel;
        logic [7:0] data;
        logic [7:0] cycles;
    } rtc_req_t;

endpackage

// ===== rtl/cartridge_bank_controller_rtc.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller with real-time clock
// Bank registers, battery RAM and clock behind one request stream.
// ----------------------------------------------------------------------------
// A request moves from the input register on to the result register only
// while the result register is empty or its result is being taken.
// Throughput: one request per cycle while results are taken; the RAM's
// single read port and write port serve each request in the cycle it
// leaves the input register. Reset: control and clock state clear at once,
// then a clearing pass zeroes all RAM_BANKS * 8192 battery RAM bytes
// (32768 by default), taking no request; configuration writes go on throughout.
module cartridge_bank_controller_rtc
    import cbc_pkg::*;
#(
    parameter int RAM_BANKS = RAM_BANKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // offset[13:0], data[21:14], cycles[29:22]
    input  logic [2:0]          s_tuser,   // command[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // read_data[7:0], rom_address[28:8]
    output logic                m_tuser,   // rom_read
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data
);

    localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int CLR_W     = ADDR_W + 1;

    // input register
    logic                 s1_valid_reg;
    cmd_t                 s1_cmd_reg;
    logic [ROM_OFF_W-1:0] s1_off_reg;
    logic [7:0]           s1_data_reg;
    logic [7:0]           s1_cycles_reg;

    // result register
    logic                  s2_valid_reg;
    logic                  s2_use_ram_reg, s2_use_ram_next;
    logic [7:0]            s2_rdata_reg, s2_rdata_next;
    logic [ROM_ADDR_W-1:0] s2_rom_addr_reg, s2_rom_addr_next;
    logic                  s2_rom_read_reg, s2_rom_read_next;

    logic [BANK_W-1:0]   rom_bank_reg, rom_bank_next;
    logic                ram_en_reg, ram_en_next;
    logic [3:0]          sel_reg, sel_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [CLR_W-1:0]    clr_cnt_reg;

    logic              clr_busy;
    logic              adv;
    logic              ram_sel;
    logic              clk_sel;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    rtc_req_t          rtc_req;
    logic [7:0]        held_rdata;
    logic [14:0]       ram_addr_full;

    assign clr_busy = clr_cnt_reg < CLR_W'(RAM_DEPTH);
    assign adv      = s1_valid_reg && (!s2_valid_reg || m_tready);
    assign s_tready = !clr_busy && (!s1_valid_reg || adv);

    assign ram_sel       = sel_reg < 4'(RAM_BANKS);
    assign clk_sel       = sel_reg >= SEL_CLK_LO && sel_reg <= SEL_CLK_HI;
    assign ram_addr_full = {sel_reg[1:0], s1_off_reg[RAM_OFF_W-1:0]};
    assign ram_addr      = ram_addr_full[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            period_reg   <= PERIOD_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (clr_busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_cmd_reg    <= cmd_t'(s_tuser);
            s1_off_reg    <= s_tdata[13:0];
            s1_data_reg   <= s_tdata[21:14];
            s1_cycles_reg <= s_tdata[29:22];
        end
        if (adv)
        begin
            s2_use_ram_reg  <= s2_use_ram_next;
            s2_rdata_reg    <= s2_rdata_next;
            s2_rom_addr_reg <= s2_rom_addr_next;
            s2_rom_read_reg <= s2_rom_read_next;
        end
    end

    // bank registers and result fields for the request in the input register
    always_comb
    begin
        rom_bank_next    = rom_bank_reg;
        ram_en_next      = ram_en_reg;
        sel_next         = sel_reg;
        s2_use_ram_next  = 1'b0;
        s2_rdata_next    = '0;
        s2_rom_addr_next = '0;
        s2_rom_read_next = 1'b0;
        ram_re           = 1'b0;
        rtc_req          = '0;
        rtc_req.reg_sel  = rtc_reg_t'(sel_reg[2:0]);
        rtc_req.data     = s1_data_reg;
        rtc_req.cycles   = s1_cycles_reg;

        case (s1_cmd_reg)
            CMD_ROM_RD:
            begin
                s2_rom_addr_next = {rom_bank_reg, s1_off_reg};
                s2_rom_read_next = 1'b1;
            end
            CMD_RAM_RD:
            begin
                if (ram_en_reg && ram_sel)
                begin
                    s2_use_ram_next = 1'b1;
                    ram_re          = adv;
                end
                else if (ram_en_reg && clk_sel)
                begin
                    s2_rdata_next = held_rdata;
                end
            end
            CMD_ENABLE:
            begin
                ram_en_next = s1_data_reg[3:0] == ENABLE_KEY;
            end
            CMD_BANK:
            begin
                rom_bank_next = (s1_data_reg[6:0] == '0) ? BANK_W'(1) : s1_data_reg[6:0];
            end
            CMD_SELECT:
            begin
                if (s1_data_reg <= 8'(SEL_RAM_HI) ||
                    (s1_data_reg >= 8'(SEL_CLK_LO) && s1_data_reg <= 8'(SEL_CLK_HI)))
                begin
                    sel_next = s1_data_reg[3:0];
                end
            end
            CMD_LATCH:
            begin
                rtc_req.latch_wr = adv;
            end
            CMD_RAM_WR:
            begin
                rtc_req.clk_wr = adv && ram_en_reg && !ram_sel && clk_sel;
            end
            CMD_TICK:
            begin
                rtc_req.tick = adv;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= BANK_W'(1);
            ram_en_reg   <= 1'b0;
            sel_reg      <= '0;
        end
        else if (adv)
        begin
            rom_bank_reg <= rom_bank_next;
            ram_en_reg   <= ram_en_next;
            sel_reg      <= sel_next;
        end
    end

    // clearing pass owns the write port until it is done
    always_comb
    begin
        if (clr_busy)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[ADDR_W-1:0];
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = adv && s1_cmd_reg == CMD_RAM_WR && ram_en_reg && ram_sel;
            ram_waddr = ram_addr;
            ram_wdata = s1_data_reg;
        end
    end

    cbc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    cbc_rtc u_rtc (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (rtc_req),
        .period_cfg (period_reg),
        .held_sel   (rtc_reg_t'(sel_reg[2:0])),
        .held_rdata (held_rdata)
    );

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {3'b000, s2_rom_addr_reg, s2_use_ram_reg ? ram_rdata : s2_rdata_reg};
    assign m_tuser  = s2_rom_read_reg;

`include "cartridge_bank_controller_rtc_assert.svh"

    `CBC_ASSERT_NOW(a_clear_blocks, clr_busy, !s_tready, "request accepted during RAM clear")
    `CBC_ASSERT_NEXT(a_rom_result, adv && s1_cmd_reg == CMD_ROM_RD,
        s2_valid_reg && s2_rom_read_reg, "ROM read did not reach the result register")
    `CBC_ASSERT_NOW(a_bank_nonzero, 1'b1, rom_bank_reg != '0, "ROM bank register is zero")
    `CBC_ASSERT_NOW(a_rom_no_data, m_tvalid && m_tuser, m_tdata[7:0] == 8'd0,
        "ROM read result carries read data")

endmodule

// ===== rtl/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cbc_rtc.sv =====
// ----------------------------------------------------------------------------
// Real-time clock
// Live counters, cycle accumulator, latch sequence and held clock bytes.
// ----------------------------------------------------------------------------
module cbc_rtc
    import cbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rtc_req_t            req,
    input  logic [PERIOD_W-1:0] period_cfg,
    input  rtc_reg_t            held_sel,
    output logic [7:0]          held_rdata
);

    logic [5:0]       sec_reg, sec_next;
    logic [5:0]       min_reg, min_next;
    logic [4:0]       hour_reg, hour_next;
    logic [8:0]       day_reg, day_next;
    logic             halt_reg, halt_next;
    logic             carry_reg, carry_next;
    logic             armed_reg, armed_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [7:0]       held_reg [5];
    logic [7:0]       held_next [5];

    logic [ACC_W-1:0] period;
    logic [ACC_W-1:0] sum;
    logic [ACC_W:0]   diff;
    logic [6:0]       sec_inc;
    logic [6:0]       min_inc;
    logic [5:0]       hour_inc;

    always_comb
    begin
        period = ({1'b0, period_cfg} < PERIOD_MIN) ? PERIOD_MIN : {1'b0, period_cfg};
        sum    = acc_reg + ACC_W'(req.cycles);
        diff   = {1'b0, sum} - {1'b0, period};
    end

    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        halt_next  = halt_reg;
        carry_next = carry_reg;
        armed_next = armed_reg;
        acc_next   = acc_reg;
        for (int i = 0; i < 5; i++)
        begin
            held_next[i] = held_reg[i];
        end
        sec_inc  = {1'b0, sec_reg} + 7'd1;
        min_inc  = {1'b0, min_reg} + 7'd1;
        hour_inc = {1'b0, hour_reg} + 6'd1;

        if (req.tick && !halt_reg)
        begin
            acc_next = sum;
            if (!diff[ACC_W])
            begin
                acc_next = diff[ACC_W-1:0];
                // carry a second through minutes, hours and days
                if (sec_inc < 7'd60)
                begin
                    sec_next = sec_inc[5:0];
                end
                else
                begin
                    sec_next = 6'(sec_inc - 7'd60);
                    if (min_inc < 7'd60)
                    begin
                        min_next = min_inc[5:0];
                    end
                    else
                    begin
                        min_next = '0;
                        if (hour_inc < 6'd24)
                        begin
                            hour_next = hour_inc[4:0];
                        end
                        else
                        begin
                            hour_next = '0;
                            if (day_reg == 9'h1FF)
                            begin
                                day_next   = '0;
                                carry_next = 1'b1;
                            end
                            else
                            begin
                                day_next = day_reg + 9'd1;
                            end
                        end
                    end
                end
            end
        end

        if (req.clk_wr)
        begin
            case (req.reg_sel)
                RTC_SEC:  sec_next  = req.data[5:0];
                RTC_MIN:  min_next  = req.data[5:0];
                RTC_HOUR: hour_next = req.data[4:0];
                RTC_DLO:  day_next  = {day_reg[8], req.data};
                RTC_DHI:
                begin
                    day_next   = {req.data[0], day_reg[7:0]};
                    halt_next  = req.data[6];
                    carry_next = req.data[7];
                end
                default: ;
            endcase
        end

        if (req.latch_wr)
        begin
            armed_next = (req.data == 8'd0);
            if (req.data == 8'd1 && armed_reg)
            begin
                held_next[0] = {2'b00, sec_reg};
                held_next[1] = {2'b00, min_reg};
                held_next[2] = {3'b000, hour_reg};
                held_next[3] = day_reg[7:0];
                held_next[4] = {carry_reg, halt_reg, 5'b00000, day_reg[8]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            day_reg   <= '0;
            halt_reg  <= 1'b0;
            carry_reg <= 1'b0;
            armed_reg <= 1'b0;
            acc_reg   <= '0;
            for (int i = 0; i < 5; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
            halt_reg  <= halt_next;
            carry_reg <= carry_next;
            armed_reg <= armed_next;
            acc_reg   <= acc_next;
            for (int i = 0; i < 5; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    always_comb
    begin
        case (held_sel)
            RTC_SEC:  held_rdata = held_reg[0];
            RTC_MIN:  held_rdata = held_reg[1];
            RTC_HOUR: held_rdata = held_reg[2];
            RTC_DLO:  held_rdata = held_reg[3];
            RTC_DHI:  held_rdata = held_reg[4];
            default:  held_rdata = '0;
        endcase
    end

endmodule
